// ----- sv/bcel_pkg.sv -----
// Shared constants for the binary cross-entropy loss block.
`default_nettype none
package bcel_pkg;
    localparam int LOG_FRAC = 30;           // fraction bits of the log datapath
    localparam int NL_W     = 35;           // width of a -ln result in Q.30
    localparam int LO_W     = 18;           // low slice width for split products
    localparam int CNT_W    = 21;           // element_count width
    localparam int LN2_W    = 28;
    localparam logic [LN2_W-1:0] LN2_Q28 = 28'd186065279;
endpackage
`default_nettype wire

// ----- sv/bcel_div.sv -----
// Bit-serial restoring divider: one quotient bit per cycle.
`default_nettype none
module bcel_div
    import bcel_pkg::*;
#(
    parameter int NUM_W = 49,
    parameter int DEN_W = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_busy,
    output logic [NUM_W-1:0]      o_quot
);
    localparam int STEP_W = $clog2(NUM_W + 1);

    logic [STEP_W-1:0] r_step;
    logic [NUM_W-1:0]  r_sh;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W:0]    trial;
    logic              q_bit;

    always_comb begin
        trial = {r_rem, r_sh[NUM_W-1]};
        q_bit = (trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (i_start) begin
            r_step <= STEP_W'(NUM_W);
        end else if (r_step != '0) begin
            r_step <= r_step - 1'b1;
        end
    end

    // numerator bits shift out the top while quotient bits shift in below
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sh  <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_step != '0) begin
            r_sh  <= {r_sh[NUM_W-2:0], q_bit};
            r_rem <= q_bit ? DEN_W'(trial - {1'b0, r_den}) : trial[DEN_W-1:0];
        end
    end

    assign o_busy = (r_step != '0);
    assign o_quot = r_sh;
endmodule
`default_nettype wire

// ----- sv/bcel_log.sv -----
// Serial -ln unit: one squaring step per cycle, then a split ln2 multiply.
`default_nettype none
module bcel_log
    import bcel_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [FRAC_BITS-1:0] i_x,
    output logic                      o_busy,
    output logic [NL_W-1:0]           o_nl
);
    localparam int H_W  = $clog2(FRAC_BITS);
    localparam int ACC_W = NL_W + LN2_W;

    typedef enum logic [3:0] {
        L_IDLE = 4'b0001,
        L_SQ   = 4'b0010,
        L_MLO  = 4'b0100,
        L_MHI  = 4'b1000
    } t_lstate;

    t_lstate r_state, n_state;
    logic [4:0]           r_step;
    logic [H_W-1:0]       r_h;
    logic [LOG_FRAC:0]    r_m;
    logic [LOG_FRAC-1:0]  r_frac;
    logic [ACC_W-1:0]     r_acc;

    logic [H_W-1:0]         h;
    logic [2*LOG_FRAC+1:0]  sq;
    logic [LOG_FRAC+1:0]    m2;
    logic [NL_W-1:0]        whole;
    logic [NL_W-1:0]        nl2;
    logic [LO_W+LN2_W-1:0]  prod_lo;
    logic [NL_W-LO_W+LN2_W-1:0] prod_hi;

    always_comb begin
        h = '0;
        for (int i = 0; i < FRAC_BITS; i++) begin
            if (i_x[i]) h = H_W'(i);
        end
        sq      = r_m * r_m;
        m2      = sq[2*LOG_FRAC+1:LOG_FRAC];
        whole   = NL_W'(FRAC_BITS) - NL_W'(r_h);
        nl2     = (whole << LOG_FRAC) - NL_W'(r_frac);
        prod_lo = nl2[LO_W-1:0] * LN2_Q28;
        prod_hi = nl2[NL_W-1:LO_W] * LN2_Q28;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            L_IDLE: if (i_start) n_state = L_SQ;
            L_SQ:   if (r_step == '0) n_state = L_MLO;
            L_MLO:  n_state = L_MHI;
            L_MHI:  n_state = L_IDLE;
            default: n_state = L_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == L_IDLE && i_start) begin
            r_h    <= h;
            r_m    <= (LOG_FRAC + 1)'(i_x) << (LOG_FRAC - int'(h));
            r_step <= 5'(LOG_FRAC - 1);
        end else if (r_state == L_SQ) begin
            // renormalize to [1,2) and shift the fraction bit in
            r_m    <= m2[LOG_FRAC+1] ? m2[LOG_FRAC+1:1] : m2[LOG_FRAC:0];
            r_frac <= {r_frac[LOG_FRAC-2:0], m2[LOG_FRAC+1]};
            r_step <= r_step - 1'b1;
        end else if (r_state == L_MLO) begin
            r_acc <= ACC_W'(prod_lo);
        end else if (r_state == L_MHI) begin
            r_acc <= r_acc + (ACC_W'(prod_hi) << LO_W) + (ACC_W'(1) << (LN2_W - 1));
        end
    end

    assign o_busy = (r_state != L_IDLE);
    assign o_nl   = r_acc[ACC_W-1:LN2_W];
endmodule
`default_nettype wire

// ----- sv/binary_cross_entropy_loss.sv -----
// Streaming binary cross-entropy loss and gradient, bit-serial datapath.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  in       | i_valid / o_ready  | i_prediction, i_target
//  out      | o_valid / i_ready  | o_gradient, o_mean_loss, o_last
//  config   | i_cfg_we           | i_cfg_data (element_count)
//
// Each item runs two bit-serial divides of 3F+1 = 49 quotient bits at F=16,
// one for the scaled gradient and one for the division by N, plus setup,
// loss accumulation and handoff. The item that closes a batch adds a third
// divide, on the second divider, for the mean.
// The two -ln units run in parallel with the first division.
// Reset is synchronous, active low; it clears the sum, the counter and N=1.
// A result waits in the output register; the next item is taken meanwhile.
`default_nettype none
module binary_cross_entropy_loss
    import bcel_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [FRAC_BITS-1:0]   i_prediction,
    input  wire logic [FRAC_BITS:0]     i_target,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic signed [FRAC_BITS+17:0] o_gradient,
    output logic [FRAC_BITS+7:0]        o_mean_loss,
    output logic                        o_last,
    input  wire logic                   i_cfg_we,
    input  wire logic [CNT_W-1:0]       i_cfg_data
);
    localparam int F        = FRAC_BITS;
    localparam int T_W      = F + 1;
    localparam int G_W      = F + 18;
    localparam int M_W      = F + 8;
    localparam int SUM_W    = F + 25;
    localparam int MN_W     = SUM_W + 1;
    localparam int D1_NUM_W = 3 * F + 1;
    localparam int D1_DEN_W = 2 * F;
    localparam int D2_W     = (F + 26 > 3 * F + 1) ? F + 26 : 3 * F + 1;
    localparam int ACC_W    = F + 37;
    localparam int LOSS_W   = ACC_W - LOG_FRAC;
    localparam logic [T_W-1:0] ONE = {1'b1, {F{1'b0}}};

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_PREP  = 11'b000_0000_0010,
        S_D1GO  = 11'b000_0000_0100,
        S_D1W   = 11'b000_0000_1000,
        S_MAC   = 11'b000_0001_0000,
        S_D2GO  = 11'b000_0010_0000,
        S_D2W   = 11'b000_0100_0000,
        S_SUM   = 11'b000_1000_0000,
        S_MGO   = 11'b001_0000_0000,
        S_MW    = 11'b010_0000_0000,
        S_FIN   = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;

    logic [CNT_W-1:0]  r_count, r_n, r_cnt;
    logic [SUM_W-1:0]  r_sum;
    logic [F-1:0]      r_p, r_q;
    logic [T_W-1:0]    r_t, r_mag;
    logic              r_neg, r_last;
    logic [D1_DEN_W-1:0] r_den;
    logic [1:0]        r_mstep;
    logic [ACC_W-1:0]  r_acc;
    logic [G_W-1:0]    r_grad;
    logic [M_W-1:0]    r_mean;
    logic [MN_W-1:0]   r_mnum;
    logic              r_ovalid, r_olast;
    logic [G_W-1:0]    r_ograd;
    logic [M_W-1:0]    r_omean;

    logic [F-1:0]      p_c;
    logic [T_W-1:0]    t_c;
    logic              neg_c;
    logic              d1_busy, d2_busy, lp_busy, lq_busy, d2_start;
    logic [D1_NUM_W-1:0] d1_quot;
    logic [D2_W-1:0]   d2_num, d2_quot, g_lim, g_mag;
    logic [NL_W-1:0]   nl_p, nl_q, op_b;
    logic [T_W-1:0]    op_a;
    logic [LO_W-1:0]   part;
    logic [T_W+LO_W-1:0] prod;
    logic [LOSS_W-1:0] loss;
    logic [SUM_W:0]    sum_add;
    logic [SUM_W-1:0]  sum_sat;
    logic [CNT_W-1:0]  cnt1;
    logic              last_c, load_out;

    always_comb begin
        p_c   = (i_prediction == '0) ? F'(1) : i_prediction;
        t_c   = (i_target > ONE) ? ONE : i_target;
        neg_c = t_c > {1'b0, p_c};
    end

    bcel_div #(.NUM_W(D1_NUM_W), .DEN_W(D1_DEN_W)) u_div_grad (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_D1GO),
        .i_num   ({r_mag, {(2 * F){1'b0}}}),
        .i_den   (r_den),
        .o_busy  (d1_busy),
        .o_quot  (d1_quot)
    );

    assign d2_start = (r_state == S_D2GO) || (r_state == S_MGO);
    assign d2_num   = (r_state == S_MGO) ? D2_W'(r_mnum) : D2_W'(d1_quot);

    bcel_div #(.NUM_W(D2_W), .DEN_W(CNT_W)) u_div_n (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (d2_start),
        .i_num   (d2_num),
        .i_den   (r_n),
        .o_busy  (d2_busy),
        .o_quot  (d2_quot)
    );

    bcel_log #(.FRAC_BITS(F)) u_log_p (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_PREP),
        .i_x     (r_p),
        .o_busy  (lp_busy),
        .o_nl    (nl_p)
    );

    bcel_log #(.FRAC_BITS(F)) u_log_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_PREP),
        .i_x     (r_q),
        .o_busy  (lq_busy),
        .o_nl    (nl_q)
    );

    always_comb begin
        // step order: t*lo(p), t*hi(p), (1-t)*lo(q), (1-t)*hi(q)
        op_a = r_mstep[1] ? (ONE - r_t) : r_t;
        op_b = r_mstep[1] ? nl_q : nl_p;
        part = r_mstep[0] ? LO_W'(op_b[NL_W-1:LO_W]) : op_b[LO_W-1:0];
        prod = op_a * part;
        loss = r_acc[ACC_W-1:LOG_FRAC];
        sum_add = {1'b0, r_sum} + (SUM_W + 1)'(loss);
        sum_sat = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
        cnt1    = r_cnt + 1'b1;
        last_c  = (cnt1 >= r_n);
        g_lim   = r_neg ? (D2_W'(1) << (G_W - 1)) : ((D2_W'(1) << (G_W - 1)) - 1'b1);
        g_mag   = (d2_quot > g_lim) ? g_lim : d2_quot;
        load_out = (r_state == S_FIN) && (!r_ovalid || i_ready);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) n_state = S_PREP;
            S_PREP: n_state = S_D1GO;
            S_D1GO: n_state = S_D1W;
            S_D1W:  if (!d1_busy && !lp_busy && !lq_busy) n_state = S_MAC;
            S_MAC:  if (r_mstep == 2'd3) n_state = S_D2GO;
            S_D2GO: n_state = S_D2W;
            S_D2W:  if (!d2_busy) n_state = S_SUM;
            S_SUM:  n_state = last_c ? S_MGO : S_FIN;
            S_MGO:  n_state = S_MW;
            S_MW:   if (!d2_busy) n_state = S_FIN;
            S_FIN:  if (load_out) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= CNT_W'(1);
            r_sum    <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_count <= i_cfg_data;
            if (r_state == S_SUM) begin
                r_sum <= last_c ? '0 : sum_sat;
                r_cnt <= last_c ? '0 : cnt1;
            end
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_p   <= p_c;
            r_q   <= F'(ONE - {1'b0, p_c});
            r_t   <= t_c;
            r_neg <= neg_c;
            r_mag <= neg_c ? t_c - {1'b0, p_c} : {1'b0, p_c} - t_c;
            r_n   <= (r_count == '0) ? CNT_W'(1) : r_count;
        end
        if (r_state == S_PREP) r_den <= r_p * r_q;
        if (r_state == S_D1W) begin
            r_acc   <= ACC_W'(1) << (LOG_FRAC - 1);
            r_mstep <= '0;
        end
        if (r_state == S_MAC) begin
            r_acc   <= r_acc + (ACC_W'(prod) << (r_mstep[0] ? LO_W : 0));
            r_mstep <= r_mstep + 1'b1;
        end
        if (r_state == S_D2W && !d2_busy) begin
            r_grad <= r_neg ? G_W'(-g_mag) : G_W'(g_mag);
        end
        if (r_state == S_SUM) begin
            r_last <= last_c;
            r_mnum <= {1'b0, sum_sat} + MN_W'(r_n >> 1);
            r_mean <= '0;
        end
        if (r_state == S_MW && !d2_busy) begin
            r_mean <= (d2_quot > D2_W'({M_W{1'b1}})) ? {M_W{1'b1}} : M_W'(d2_quot);
        end
        if (load_out) begin
            r_ograd <= r_grad;
            r_omean <= r_mean;
            r_olast <= r_last;
        end
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_valid     = r_ovalid;
    assign o_gradient  = r_ograd;
    assign o_mean_loss = r_omean;
    assign o_last      = r_olast;

    a_mean_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !r_olast) |-> (r_omean == '0))
        else $error("mean_loss nonzero on a beat that is not last");

    a_batch_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM && last_c) |=> (r_cnt == '0 && r_sum == '0))
        else $error("batch state not cleared after last element");

    a_logs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC) |-> (!lp_busy && !lq_busy && !d1_busy))
        else $error("loss accumulation started before logarithms finished");

    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        d2_start |-> !d2_busy)
        else $error("divider restarted while busy");
endmodule
`default_nettype wire
